// ===== rtl/truncated_octahedron_min_image_defines.svh =====
// Assertion macros shared by the checker of the minimum-image block.
`ifndef TRUNCATED_OCTAHEDRON_MIN_IMAGE_DEFINES_SVH
`define TRUNCATED_OCTAHEDRON_MIN_IMAGE_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define TOMI_CHK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TOMI_CHK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tomi_pkg.sv =====
// Shared types and constants of the truncated-octahedron minimum-image block.
package tomi_pkg;

  localparam int NUM_AXES    = 3;
  localparam int RECIP_W     = 32;
  localparam int HALF_BOX_W  = 31;
  localparam int GM_W        = 32;   // Q0.32 fraction magnitude
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // Pipeline stage positions
  localparam int ST_MAG     = 0;
  localparam int ST_PP      = 1;
  localparam int ST_M       = 2;
  localparam int ST_HALF    = 3;
  localparam int ST_SUM     = 4;
  localparam int ST_FOLD    = 5;
  localparam int ST_MUL     = 6;
  localparam int ST_OUT     = 7;
  localparam int NUM_STAGES = 8;

  localparam logic [GM_W-1:0] HALF_Q32          = 32'h8000_0000;
  localparam logic [GM_W+1:0] THREE_QUARTER_Q32 = 34'h0_C000_0000;

  localparam logic [HALF_BOX_W-1:0] HALF_BOX_RST = 31'd655360;
  localparam logic [RECIP_W-1:0]    RECIP_RST    = 32'd214748365;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HALF_BOX_X    = 3'd0,
    REG_HALF_BOX_Y    = 3'd1,
    REG_HALF_BOX_Z    = 3'd2,
    REG_RECIP_X       = 3'd3,
    REG_RECIP_Y       = 3'd4,
    REG_RECIP_Z       = 3'd5,
    REG_PASS_THROUGH  = 3'd6
  } tomi_reg_t;

  // Load enables of the forward-scaling stages of one lane
  typedef struct packed {
    logic ld_mag;
    logic ld_pp;
    logic ld_m;
    logic ld_half;
  } tomi_fwd_ctl_t;

endpackage

// ===== rtl/tomi_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
interface tomi_in_if #(parameter int COORD_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface tomi_out_if #(parameter int COORD_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          corner_folded;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output corner_folded, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input corner_folded, output ready);
endinterface

// ===== rtl/truncated_octahedron_min_image.sv =====
// Truncated-octahedron minimum-image fold of one Q16.16 displacement per transfer.
// An input passes stages MAG, PP, M, HALF, SUM, FOLD and MUL into the output register.
// Throughput: one vector per cycle unless the output stalls, which holds only full stages.
// The depth is set by the split forward multiply and the 32x32 back multiply per axis.
// Reset (rst_n low, synchronous) empties the pipeline and restores register defaults.
module truncated_octahedron_min_image #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int COORD_WIDTH     = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tomi_in_if.sink                            in_chan,
  tomi_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [tomi_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tomi_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tomi_pkg::*;

  // Configuration registers
  logic [HALF_BOX_W-1:0] half_box_r [NUM_AXES];
  logic [RECIP_W-1:0]    recip_r    [NUM_AXES];
  logic                  pass_r;

  // Pipeline control: one valid bit per stage, loads ripple back from the output
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] stage_en;
  tomi_fwd_ctl_t         fwd_ctl;

  // Payload
  logic signed [COORD_WIDTH-1:0] coord_in [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] raw_r    [ST_OUT][NUM_AXES];
  logic [GM_W-1:0]               frac_gm  [NUM_AXES];
  logic                          frac_gneg[NUM_AXES];
  logic [GM_W-1:0]               gm4_r    [NUM_AXES];
  logic                          gneg4_r  [NUM_AXES];
  logic [GM_W-1:0]               gm5_r    [NUM_AXES];
  logic                          gneg5_r  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] scaled   [NUM_AXES];
  logic                          fold4_r, fold5_r, fold6_r;
  logic [GM_W+1:0]               frac_sum;
  logic signed [COORD_WIDTH-1:0] out_x_r, out_y_r, out_z_r;
  logic                          folded_r;

  // ---------------------------------------------------------------------------
  // Configuration writes; indexes past the register list are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        half_box_r[i] <= HALF_BOX_RST;
        recip_r[i]    <= RECIP_RST;
      end
      pass_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_BOX_X:   half_box_r[0] <= cfg_data[HALF_BOX_W-1:0];
        REG_HALF_BOX_Y:   half_box_r[1] <= cfg_data[HALF_BOX_W-1:0];
        REG_HALF_BOX_Z:   half_box_r[2] <= cfg_data[HALF_BOX_W-1:0];
        REG_RECIP_X:      recip_r[0]    <= cfg_data[RECIP_W-1:0];
        REG_RECIP_Y:      recip_r[1]    <= cfg_data[RECIP_W-1:0];
        REG_RECIP_Z:      recip_r[2]    <= cfg_data[RECIP_W-1:0];
        REG_PASS_THROUGH: pass_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or the stage after it
  // advances. Bubbles collapse, so a stalled output still lets the front fill.
  // ---------------------------------------------------------------------------
  always_comb begin
    stage_en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_chan.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  assign in_chan.ready = stage_en[ST_MAG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  always_comb begin
    fwd_ctl.ld_mag  = stage_en[ST_MAG];
    fwd_ctl.ld_pp   = stage_en[ST_PP];
    fwd_ctl.ld_m    = stage_en[ST_M];
    fwd_ctl.ld_half = stage_en[ST_HALF];
  end

  always_comb begin
    coord_in[0] = in_chan.in_x;
    coord_in[1] = in_chan.in_y;
    coord_in[2] = in_chan.in_z;
  end

  // Raw vector travels alongside for the bypass mode
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      raw_r[0] <= coord_in;
    end
    for (int k = 1; k < ST_OUT; k++) begin
      if (stage_en[k]) begin
        raw_r[k] <= raw_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Per-axis lanes: forward scaling (stages 0-3) and back scaling (stage 6)
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    tomi_frac #(
      .COORD_WIDTH     (COORD_WIDTH),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_frac (
      .clk   (clk),
      .ctl   (fwd_ctl),
      .coord (coord_in[i]),
      .recip (recip_r[i]),
      .gm    (frac_gm[i]),
      .gneg  (frac_gneg[i])
    );

    tomi_scale #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_scale (
      .clk      (clk),
      .ld       (stage_en[ST_MUL]),
      .gm       (gm5_r[i]),
      .gneg     (gneg5_r[i]),
      .half_box (half_box_r[i]),
      .res      (scaled[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Octahedral test: fold when |fx|+|fy|+|fz| is strictly above three quarters.
  // ---------------------------------------------------------------------------
  always_comb begin
    frac_sum = (GM_W+2)'(frac_gm[0]) + (GM_W+2)'(frac_gm[1]) + (GM_W+2)'(frac_gm[2]);
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_SUM]) begin
      gm4_r   <= frac_gm;
      gneg4_r <= frac_gneg;
      fold4_r <= frac_sum > THREE_QUARTER_Q32;
    end
  end

  // Half-period shift toward zero: magnitude becomes one half minus the old
  // magnitude and the sign flips (a zero fraction counts as positive).
  always_ff @(posedge clk) begin
    if (stage_en[ST_FOLD]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        gm5_r[i]   <= fold4_r ? (HALF_Q32 - gm4_r[i]) : gm4_r[i];
        gneg5_r[i] <= fold4_r ? !gneg4_r[i] : gneg4_r[i];
      end
      fold5_r <= fold4_r;
    end
    if (stage_en[ST_MUL]) begin
      fold6_r <= fold5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: pick the raw vector in bypass mode.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (stage_en[ST_OUT]) begin
      if (pass_r) begin
        out_x_r  <= raw_r[ST_OUT-1][0];
        out_y_r  <= raw_r[ST_OUT-1][1];
        out_z_r  <= raw_r[ST_OUT-1][2];
        folded_r <= 1'b0;
      end else begin
        out_x_r  <= scaled[0];
        out_y_r  <= scaled[1];
        out_z_r  <= scaled[2];
        folded_r <= fold6_r;
      end
    end
  end

  assign out_chan.valid         = valid_r[ST_OUT];
  assign out_chan.out_x         = out_x_r;
  assign out_chan.out_y         = out_y_r;
  assign out_chan.out_z         = out_z_r;
  assign out_chan.corner_folded = folded_r;

endmodule

// ===== rtl/tomi_frac.sv =====
// Forward scaling of one coordinate into a half-folded Q0.32 fraction, four stages.
module tomi_frac #(
  parameter int COORD_WIDTH     = 32,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  tomi_pkg::tomi_fwd_ctl_t       ctl,
  input  logic signed [COORD_WIDTH-1:0] coord,
  input  logic [tomi_pkg::RECIP_W-1:0]  recip,
  output logic [tomi_pkg::GM_W-1:0]     gm,
  output logic                          gneg
);
  import tomi_pkg::*;

  localparam int LO_W = (COORD_WIDTH + 1) / 2;
  localparam int HI_W = COORD_WIDTH - LO_W;
  localparam int PW   = ((COORD_WIDTH > COORD_FRAC_BITS) ? COORD_WIDTH : COORD_FRAC_BITS)
                        + GM_W;

  logic                     neg0_r, neg1_r, neg2_r, gneg_r;
  logic [COORD_WIDTH-1:0]   mag0_r, mag_nxt;
  logic [LO_W+RECIP_W-1:0]  pl_r, pl_nxt;
  logic [HI_W+RECIP_W-1:0]  ph_r, ph_nxt;
  logic [PW-1:0]            prod;
  logic [GM_W-1:0]          m2_r, gm_r, gm_nxt;
  logic                     neg_h, gneg_nxt;

  // Magnitude of the two's complement coordinate
  always_comb begin
    mag_nxt = coord[COORD_WIDTH-1] ? (~coord + COORD_WIDTH'(1)) : coord;
  end

  // Split product: low and high halves of the magnitude times the reciprocal
  always_comb begin
    pl_nxt = (LO_W+RECIP_W)'(mag0_r[LO_W-1:0]) * (LO_W+RECIP_W)'(recip);
    ph_nxt = (HI_W+RECIP_W)'(mag0_r[COORD_WIDTH-1:LO_W]) * (HI_W+RECIP_W)'(recip);
  end

  // Recombine and keep the fraction bits, dropping the whole part
  always_comb begin
    prod = PW'(pl_r) + (PW'(ph_r) << LO_W);
  end

  // Fold a fraction of one half or more to the other side
  always_comb begin
    gm_nxt   = m2_r[GM_W-1] ? (~m2_r + GM_W'(1)) : m2_r;
    neg_h    = neg2_r ^ m2_r[GM_W-1];
    gneg_nxt = neg_h && (gm_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_mag) begin
      neg0_r <= coord[COORD_WIDTH-1];
      mag0_r <= mag_nxt;
    end
    if (ctl.ld_pp) begin
      neg1_r <= neg0_r;
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
    end
    if (ctl.ld_m) begin
      neg2_r <= neg1_r;
      m2_r   <= prod[COORD_FRAC_BITS+GM_W-1:COORD_FRAC_BITS];
    end
    if (ctl.ld_half) begin
      gm_r   <= gm_nxt;
      gneg_r <= gneg_nxt;
    end
  end

  assign gm   = gm_r;
  assign gneg = gneg_r;

endmodule

// ===== rtl/tomi_scale.sv =====
// Back scaling of one fraction by the period, with saturation to the coordinate range.
module tomi_scale #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            ld,
  input  logic [tomi_pkg::GM_W-1:0]       gm,
  input  logic                            gneg,
  input  logic [tomi_pkg::HALF_BOX_W-1:0] half_box,
  output logic signed [COORD_WIDTH-1:0]   res
);
  import tomi_pkg::*;

  localparam int RW     = HALF_BOX_W + 1;
  localparam int PROD_W = GM_W + RW;
  localparam int EW     = ((COORD_WIDTH > RW) ? COORD_WIDTH : RW) + 1;
  localparam logic [EW-1:0] LIM_NEG = EW'(1) << (COORD_WIDTH - 1);
  localparam logic [EW-1:0] LIM_POS = LIM_NEG - EW'(1);

  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic                   neg_r;
  logic [EW-1:0]          r_ext, mag_sat;
  logic [COORD_WIDTH-1:0] mag_w;

  always_comb begin
    prod_nxt = PROD_W'(gm) * PROD_W'({half_box, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      prod_r <= prod_nxt;
      neg_r  <= gneg;
    end
  end

  // Truncate toward zero, clamp, then apply the sign
  always_comb begin
    r_ext = EW'(prod_r[PROD_W-1:GM_W]);
    if (neg_r) begin
      mag_sat = (r_ext > LIM_NEG) ? LIM_NEG : r_ext;
    end else begin
      mag_sat = (r_ext > LIM_POS) ? LIM_POS : r_ext;
    end
    mag_w = mag_sat[COORD_WIDTH-1:0];
    res   = neg_r ? (~mag_w + COORD_WIDTH'(1)) : mag_w;
  end

endmodule

// ===== rtl/tomi_checker.sv =====
// Port-level checker of the minimum-image block and its bind statement.
`include "truncated_octahedron_min_image_defines.svh"

module tomi_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_WIDTH-1:0] out_x,
  input logic signed [COORD_WIDTH-1:0] out_y,
  input logic signed [COORD_WIDTH-1:0] out_z,
  input logic                          out_folded
);
  import tomi_pkg::*;

  localparam int CNT_W = $clog2(NUM_STAGES + 1);

  logic [CNT_W-1:0] inflight_r, inflight_nxt;

  // Count transfers in flight between the two channels
  always_comb begin
    inflight_nxt = inflight_r;
    if (in_valid && in_ready) begin
      inflight_nxt = inflight_nxt + CNT_W'(1);
    end
    if (out_valid && out_ready) begin
      inflight_nxt = inflight_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `TOMI_CHK_NR(a_reset_empties, clk, !rst_n |=> !out_valid, "output valid after reset")
  `TOMI_CHK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_folded), "stalled result changed")
  `TOMI_CHK(a_no_invented, clk, rst_n, out_valid |-> inflight_r != '0, "result without a pending input")
  `TOMI_CHK(a_depth, clk, rst_n, inflight_r <= CNT_W'(NUM_STAGES), "more items in flight than stages")
  `TOMI_CHK(a_flow, clk, rst_n, out_ready |-> in_ready, "input stalled while output drains")

endmodule

bind truncated_octahedron_min_image tomi_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_tomi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_x      (out_chan.out_x),
  .out_y      (out_chan.out_y),
  .out_z      (out_chan.out_z),
  .out_folded (out_chan.corner_folded)
);
